>>> design/salsa_pkg.sv
// Shared types, constants and helper functions for the Salsa20 stream cipher.
package salsa_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_WB
    } state_t;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd5;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    typedef struct packed
    {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } qr_words_t;

    typedef struct packed
    {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic [3:0] d;
    } qr_idx_t;

    // Word positions of each quarter-round: four column steps, then four row steps.
    function automatic qr_idx_t qr_select(input logic [2:0] qr);
        qr_idx_t s;
        case (qr)
            3'd0:    s = '{4'd0,  4'd4,  4'd8,  4'd12};
            3'd1:    s = '{4'd5,  4'd9,  4'd13, 4'd1};
            3'd2:    s = '{4'd10, 4'd14, 4'd2,  4'd6};
            3'd3:    s = '{4'd15, 4'd3,  4'd7,  4'd11};
            3'd4:    s = '{4'd0,  4'd1,  4'd2,  4'd3};
            3'd5:    s = '{4'd5,  4'd6,  4'd7,  4'd4};
            3'd6:    s = '{4'd10, 4'd11, 4'd8,  4'd9};
            3'd7:    s = '{4'd15, 4'd12, 4'd13, 4'd14};
            default: s = '{4'd0,  4'd4,  4'd8,  4'd12};
        endcase
        return s;
    endfunction

    // Input state word at position idx.
    function automatic logic [31:0] init_word(
        input logic [3:0]  idx,
        input logic [63:0] k0,
        input logic [63:0] k1,
        input logic [63:0] k2,
        input logic [63:0] k3,
        input logic [63:0] nonce,
        input logic [63:0] ctr
    );
        logic [31:0] w;
        case (idx)
            4'd0:    w = SIGMA0;
            4'd1:    w = k0[31:0];
            4'd2:    w = k0[63:32];
            4'd3:    w = k1[31:0];
            4'd4:    w = k1[63:32];
            4'd5:    w = SIGMA1;
            4'd6:    w = nonce[31:0];
            4'd7:    w = nonce[63:32];
            4'd8:    w = ctr[31:0];
            4'd9:    w = ctr[63:32];
            4'd10:   w = SIGMA2;
            4'd11:   w = k2[31:0];
            4'd12:   w = k2[63:32];
            4'd13:   w = k3[31:0];
            4'd14:   w = k3[63:32];
            4'd15:   w = SIGMA3;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

>>> design/salsa_qr.sv
// Salsa20 quarter-round: four add-rotate-xor steps on one word group.
module salsa_qr
(
    input  salsa_pkg::qr_words_t din,
    output salsa_pkg::qr_words_t dout
);
    import salsa_pkg::*;

    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] s3;
    logic [31:0] s4;
    logic [31:0] b1;
    logic [31:0] c1;
    logic [31:0] d1;
    logic [31:0] a1;

    always_comb
    begin
        s1 = din.a + din.d;
        b1 = din.b ^ {s1[24:0], s1[31:25]};
        s2 = b1 + din.a;
        c1 = din.c ^ {s2[22:0], s2[31:23]};
        s3 = c1 + b1;
        d1 = din.d ^ {s3[18:0], s3[31:19]};
        s4 = d1 + c1;
        a1 = din.a ^ {s4[13:0], s4[31:14]};
        dout = '{a1, b1, c1, d1};
    end

endmodule

>>> design/salsa20_stream_cipher_top.sv
// Salsa20/20 byte stream cipher: keystream generation and byte combine.
// A byte inside a block goes from ST_IDLE to ST_WB and then into the output register.
// A byte that opens a block first passes ST_LOAD, ST_ROUND and ST_ADD:
// one quarter-round per cycle on the shared unit, then the sixteen final word adds.
// The input takes no new byte until the previous one is written to the output register.
// Reset (async, active low): control and config registers clear, fresh flag sets; message restarts at start counter.
module salsa20_stream_cipher_top
#(
    parameter int DOUBLE_ROUNDS = 10
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] data_byte
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,   // [7:0] out_byte
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [salsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                        cfg_data
);
    import salsa_pkg::*;

    localparam int STEPS  = 8 * DOUBLE_ROUNDS;
    localparam int STEP_W = $clog2(STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

    state_t state_reg;
    state_t state_next;

    logic [63:0]       key0_reg;
    logic [63:0]       key1_reg;
    logic [63:0]       key2_reg;
    logic [63:0]       key3_reg;
    logic [63:0]       nonce_reg;
    logic [63:0]       start_reg;
    logic [63:0]       ctr_reg;
    logic [5:0]        pos_reg;
    logic              fresh_reg;
    logic [STEP_W-1:0] step_reg;
    logic [3:0]        word_cnt_reg;
    logic [7:0]        data_reg;
    logic              last_reg;
    logic [31:0]       work_reg [16];
    logic [31:0]       ks_mem [16];
    logic [31:0]       rd_word_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    logic      in_fire;
    logic      wb_go;
    qr_idx_t   sel;
    qr_words_t qr_in;
    qr_words_t qr_out;
    logic [31:0] add_word;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign wb_go         = (state_reg == ST_WB) && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    assign sel      = qr_select(step_reg[2:0]);
    assign add_word = work_reg[0] + init_word(word_cnt_reg, key0_reg, key1_reg, key2_reg,
                                              key3_reg, nonce_reg, ctr_reg);

    always_comb
    begin
        qr_in = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (4'(i) == sel.a) qr_in.a = work_reg[i];
            if (4'(i) == sel.b) qr_in.b = work_reg[i];
            if (4'(i) == sel.c) qr_in.c = work_reg[i];
            if (4'(i) == sel.d) qr_in.d = work_reg[i];
        end
    end

    salsa_qr u_qr
    (
        .din  (qr_in),
        .dout (qr_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = (fresh_reg || pos_reg == 6'd0) ? ST_LOAD : ST_WB;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (step_reg == STEP_LAST) state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (word_cnt_reg == 4'd15) state_next = ST_WB;
            end
            ST_WB:
            begin
                if (wb_go) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            nonce_reg     <= '0;
            start_reg     <= '0;
            ctr_reg       <= '0;
            pos_reg       <= '0;
            fresh_reg     <= 1'b1;
            step_reg      <= '0;
            word_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY0:  key0_reg  <= cfg_data;
                    CFG_KEY1:  key1_reg  <= cfg_data;
                    CFG_KEY2:  key2_reg  <= cfg_data;
                    CFG_KEY3:  key3_reg  <= cfg_data;
                    CFG_NONCE: nonce_reg <= cfg_data;
                    CFG_START: start_reg <= cfg_data;
                    default:   ;
                endcase
            end

            if (in_fire && fresh_reg)
            begin
                ctr_reg   <= start_reg;
                pos_reg   <= '0;
                fresh_reg <= 1'b0;
            end

            if (state_reg == ST_LOAD)
            begin
                step_reg     <= '0;
                word_cnt_reg <= '0;
            end

            if (state_reg == ST_ROUND)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end

            if (state_reg == ST_ADD)
            begin
                word_cnt_reg <= word_cnt_reg + 4'd1;
                if (word_cnt_reg == 4'd15) ctr_reg <= ctr_reg + 64'd1;
            end

            if (wb_go)
            begin
                pos_reg       <= pos_reg + 6'd1;
                fresh_reg     <= last_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working words and item payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            data_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end

        case (state_reg)
            ST_LOAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    work_reg[i] <= init_word(4'(i), key0_reg, key1_reg, key2_reg,
                                             key3_reg, nonce_reg, ctr_reg);
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    if (4'(i) == sel.a) work_reg[i] <= qr_out.a;
                    if (4'(i) == sel.b) work_reg[i] <= qr_out.b;
                    if (4'(i) == sel.c) work_reg[i] <= qr_out.c;
                    if (4'(i) == sel.d) work_reg[i] <= qr_out.d;
                end
            end
            ST_ADD:
            begin
                // words leave through position 0, one a cycle
                for (int i = 0; i < 15; i++)
                begin
                    work_reg[i] <= work_reg[i+1];
                end
            end
            default:
            begin
            end
        endcase

        if (wb_go)
        begin
            out_byte_reg <= data_reg ^ rd_word_reg[{pos_reg[1:0], 3'b000} +: 8];
            out_last_reg <= last_reg;
        end
    end

    // Keystream store, one 32-bit word per entry, little-endian bytes
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ADD)
        begin
            ks_mem[word_cnt_reg] <= add_word;
        end
        rd_word_reg <= ks_mem[pos_reg[5:2]];
    end

endmodule

>>> design/salsa_chk.sv
// Port-level checks for the Salsa20 stream cipher, bound to the top level.
module salsa_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

    // one item at a time: input closes after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted back to back");

    // a result never shows up in the cycle right after its accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind salsa20_stream_cipher_top salsa_chk u_salsa_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
